@@ design/rrc_pkg.sv @@
// Shared types and constants for the range remap chain.
package rrc_pkg;

  // Request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  // Width and reset value of the stages-in-use register
  localparam int unsigned CFG_W = 4;
  localparam logic [CFG_W-1:0] STAGES_RESET = 4'd7;

  // One input request
  typedef struct packed {
    logic        opcode;
    logic [2:0]  stage_index;
    logic [4:0]  slot_index;
    logic [31:0] value;
    logic [31:0] dest_start;
    logic [31:0] span_length;
  } rrc_req_t;

  // One result
  typedef struct packed {
    logic [31:0] translated;
    logic [31:0] room_left;
    logic        any_matched;
    logic [31:0] running_min;
  } rrc_rsp_t;

  // Table write broadcast to every cell
  typedef struct packed {
    logic        en;
    logic [2:0]  stage;
    logic [4:0]  slot;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] len;
  } rrc_wr_t;

  // Translate token handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic [31:0] value;
    logic [31:0] room;
    logic        hit;
  } rrc_tok_t;

endpackage

@@ design/rrc_cell.sv @@
// One translation stage: holds its range table and remaps the passing token.
module rrc_cell #(
  parameter int unsigned ENTRIES  = 32,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rrc_pkg::rrc_wr_t  wr_i,
  input  logic             use_i,
  input  rrc_pkg::rrc_tok_t tok_i,
  output rrc_pkg::rrc_tok_t tok_o
);
  import rrc_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Table: source start, precomputed offset (dst - src) and exclusive end
  logic [31:0] src_q   [ENTRIES];
  logic [31:0] delta_q [ENTRIES];
  logic [32:0] end_q   [ENTRIES];

  logic          wr_hit;
  logic [IW-1:0] wr_idx;
  logic [31:0]   delta_d;
  logic [32:0]   end_d;

  logic [ENTRIES-1:0] hit;
  logic [ENTRIES-1:0] first;
  logic [31:0]        delta_sel;
  logic [31:0]        end_sel;
  logic               any_hit;
  logic [31:0]        room_e;
  rrc_tok_t           tok_d;
  rrc_tok_t           tok_q;

  // Write decode
  assign wr_hit  = wr_i.en && (5'(wr_i.stage) == 5'(CELL_IDX))
                 && (9'(wr_i.slot) < 9'(ENTRIES));
  assign wr_idx  = IW'(wr_i.slot);
  assign delta_d = wr_i.dst - wr_i.src;
  assign end_d   = {1'b0, wr_i.src} + {1'b0, wr_i.len};

  // Source and end reset to zero so every entry starts empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ENTRIES; k++) begin
        src_q[k] <= '0;
        end_q[k] <= '0;
      end
    end else if (wr_hit) begin
      src_q[wr_idx] <= wr_i.src;
      end_q[wr_idx] <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      delta_q[wr_idx] <= delta_d;
    end
  end

  // Parallel range compare; an empty entry has end == src and never hits
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      hit[k] = (tok_i.value >= src_q[k]) && ({1'b0, tok_i.value} < end_q[k]);
    end
  end

  // Lowest slot wins
  assign first = hit & (~hit + ENTRIES'(1));

  always_comb begin
    delta_sel = '0;
    end_sel   = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      delta_sel = delta_sel | ({32{first[k]}} & delta_q[k]);
      end_sel   = end_sel   | ({32{first[k]}} & end_q[k][31:0]);
    end
  end

  assign any_hit = use_i && (|hit);
  // end - 1 - v, which fits in 32 bits on a hit
  assign room_e  = end_sel + ~tok_i.value;

  // Remap and track the least room
  always_comb begin
    tok_d = tok_i;
    if (any_hit) begin
      tok_d.value = tok_i.value + delta_sel;
      tok_d.hit   = 1'b1;
      if (room_e < tok_i.room) begin
        tok_d.room = room_e;
      end
    end
  end

  // Hand-off register to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ design/range_remap_chain.sv @@
// Top level of the range remap chain: request decode, cell row and result register.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+--------------------------------
//  request  | start, busy, req_i             | taken when start && !busy
//  result   | done_o, rsp_o                  | one-cycle strobe, no back-pressure
//  config   | cfg_valid_i, cfg_ready_o,      | written when valid && ready
//           | cfg_data_i                     |
//
// A table write does not set busy, so the next request may follow at once.
// A translate walks one cell per cycle, through each cell's hand-off register;
// done_o rises from the result register after the last cell and busy drops
// with it. Busy holds off requests for that whole walk, so one translate is
// in the row at a time and it always sees the table as it stood when it was
// taken. Reset empties every table entry at once, sets the running minimum to
// all ones and stages in use to 7. The result side never stalls the block.
module range_remap_chain #(
  parameter int unsigned STAGE_COUNT       = 8,
  parameter int unsigned ENTRIES_PER_STAGE = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  rrc_pkg::rrc_req_t             req_i,
  output logic                          done_o,
  output rrc_pkg::rrc_rsp_t             rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rrc_pkg::CFG_W-1:0]     cfg_data_i
);
  import rrc_pkg::*;

  logic [CFG_W-1:0] stages_q;
  logic             busy_q;
  logic             take;
  rrc_wr_t          wr;
  rrc_tok_t         tok [STAGE_COUNT+1];
  logic             cell_use [STAGE_COUNT];
  rrc_tok_t         last;
  logic [31:0]      least_q;
  logic [31:0]      least_d;
  rrc_rsp_t         rsp_q;
  logic             done_q;

  // Config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stages_q <= STAGES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      stages_q <= cfg_data_i;
    end
  end

  // Request decode
  assign take = start && !busy_q;

  assign wr.en    = take && (req_i.opcode == OP_WRITE);
  assign wr.stage = req_i.stage_index;
  assign wr.slot  = req_i.slot_index;
  assign wr.src   = req_i.value;
  assign wr.dst   = req_i.dest_start;
  assign wr.len   = req_i.span_length;

  assign tok[0].valid = take && (req_i.opcode == OP_XLATE);
  assign tok[0].value = req_i.value;
  assign tok[0].room  = '1;
  assign tok[0].hit   = 1'b0;

  // Row of cells; a cell past stages in use passes the token unchanged
  for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_cell
    assign cell_use[s] = ({1'b0, stages_q} > 5'(s));

    rrc_cell #(
      .ENTRIES  (ENTRIES_PER_STAGE),
      .CELL_IDX (s)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr),
      .use_i  (cell_use[s]),
      .tok_i  (tok[s]),
      .tok_o  (tok[s+1])
    );
  end

  assign last = tok[STAGE_COUNT];

  // Running minimum
  assign least_d = (last.value < least_q) ? last.value : least_q;

  // Busy and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      least_q <= '1;
    end else begin
      done_q <= last.valid;
      if (tok[0].valid) begin
        busy_q <= 1'b1;
      end else if (last.valid) begin
        busy_q <= 1'b0;
      end
      if (last.valid) begin
        least_q <= least_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (last.valid) begin
      rsp_q.translated  <= last.value;
      rsp_q.room_left   <= last.hit ? last.room : '0;
      rsp_q.any_matched <= last.hit;
      rsp_q.running_min <= least_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
